### src/wmad_pkg.sv
// Shared types and constants for the weighted mean absolute deviation block.
// Used by wmad_front, wmad_div, wmad_back and weighted_mean_abs_deviation.
package wmad_pkg;

  localparam int MAX_CLASSES = 256;

  localparam int MARK_W = 32;
  localparam int FREQ_W = 16;
  localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int IDX_W  = $clog2(MAX_CLASSES);
  localparam int TOT_W  = FREQ_W + CNT_W;
  localparam int WSUM_W = MARK_W + FREQ_W + CNT_W;
  localparam int PROD_W = MARK_W + FREQ_W + 1;
  localparam int DEV_W  = MARK_W + 1;
  localparam int DEVP_W = DEV_W + FREQ_W;
  localparam int DEVS_W = DEV_W + TOT_W;
  localparam int DIVD_W = DEVS_W;
  localparam int DCNT_W = $clog2(DIVD_W + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef enum logic {
    K_STORE,
    K_DROP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic [MARK_W-1:0]  mark;
    logic [FREQ_W-1:0]  freq;
  } item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETTLE,
    S_CHECK,
    S_MDIV,
    S_PASS,
    S_DDIV,
    S_OUT
  } bk_state_t;

  typedef struct packed {
    logic q_nonempty;
    logic q_full;
  } fe_stat_t;

  typedef struct packed {
    logic in_load;
    logic div_busy;
  } bk_stat_t;

endpackage

### src/wmad_front.sv
// Front end: accepts input transactions, assigns store slots or marks overflow,
// and queues classified items for the back end. Depends on wmad_pkg.
module wmad_front import wmad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [MARK_W-1:0] mark,
  input  logic [FREQ_W-1:0] freq,
  input  logic              last,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_ready,
  output fe_stat_t          stat
);

  item_t               q_mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     level;
  logic [CNT_W-1:0]    count;
  logic                push;
  logic                pop;
  item_t               new_item;

  assign s_tready = (level != (QPTR_W + 1)'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (level != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = q_mem[rd_ptr];

  assign stat.q_nonempty = q_valid;
  assign stat.q_full     = !s_tready;

  always_comb begin
    new_item.kind = (count < CNT_W'(MAX_CLASSES)) ? K_STORE : K_DROP;
    new_item.last = last;
    new_item.idx  = count[IDX_W-1:0];
    new_item.mark = mark;
    new_item.freq = freq;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        // The slot counter restarts with each data set.
        if (last) begin
          count <= '0;
        end else if (new_item.kind == K_STORE) begin
          count <= count + 1'b1;
        end
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

### src/wmad_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on wmad_pkg for the dividend and divisor widths.
module wmad_div import wmad_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [TOT_W-1:0]  divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic              done,
  output logic              busy
);

  logic [DIVD_W-1:0] quo;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  dvs;
  logic [DCNT_W-1:0] cnt;
  logic [TOT_W:0]    shifted;
  logic              fits;

  assign shifted  = {rem, quo[DIVD_W-1]};
  assign fits     = (shifted >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVD_W-2:0], fits};
      rem <= fits ? TOT_W'(shifted - {1'b0, dvs}) : shifted[TOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DCNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### src/wmad_back.sv
// Back end: stores pairs, accumulates the sums, then, unless the set overflowed or has zero total,
// runs the mean division, the deviation pass over the stored pairs and the final division.
// Depends on wmad_pkg and wmad_div.
module wmad_back import wmad_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  item_t         q_item,
  output logic          q_ready,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,
  output logic [1:0]    m_tuser,
  output bk_stat_t      stat
);

  bk_state_t                   state;
  bk_state_t                   state_next;

  logic [MARK_W+FREQ_W-1:0]    mem [MAX_CLASSES];
  logic [MARK_W+FREQ_W-1:0]    rd_word;

  logic [CNT_W-1:0]            n_stored;
  logic [TOT_W-1:0]            total;
  logic signed [WSUM_W-1:0]    wsum;
  logic [WSUM_W-1:0]           wsum_mag;
  logic                        ovf;
  logic signed [PROD_W-1:0]    prod;
  logic                        prod_v;

  logic [MARK_W-1:0]           res_mean;
  logic [31:0]                 res_dev;
  logic [1:0]                  res_status;

  logic [CNT_W-1:0]            rd_idx;
  logic                        issue;
  logic                        rd_v;
  logic [DEV_W-1:0]            adiff_r;
  logic [FREQ_W-1:0]           freq_r;
  logic                        adiff_v;
  logic [DEVP_W-1:0]           dprod;
  logic                        dprod_v;
  logic [DEVS_W-1:0]           dev_sum;
  logic                        pass_end;
  logic signed [DEV_W-1:0]     diff;
  logic [DEV_W-1:0]            adiff;

  logic                        pop;
  logic                        out_load;
  logic                        div_start;
  logic [DIVD_W-1:0]           div_dividend;
  logic [DIVD_W-1:0]           div_q;
  logic                        div_done;
  logic                        div_busy;

  wmad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (total),
    .quotient (div_q),
    .done     (div_done),
    .busy     (div_busy)
  );

  assign pop      = q_valid && q_ready;
  assign wsum_mag = wsum[WSUM_W-1] ? WSUM_W'(-wsum) : WSUM_W'(wsum);
  assign issue    = (state == S_PASS) && (rd_idx < n_stored);
  assign pass_end = (state == S_PASS) && !issue && !rd_v && !adiff_v && !dprod_v;

  assign diff  = $signed({rd_word[MARK_W+FREQ_W-1], rd_word[MARK_W+FREQ_W-1:FREQ_W]})
               - $signed({res_mean[MARK_W-1], res_mean});
  assign adiff = diff[DEV_W-1] ? DEV_W'(-diff) : DEV_W'(diff);

  assign stat.in_load  = (state == S_LOAD);
  assign stat.div_busy = div_busy;

  always_comb begin
    state_next   = state;
    q_ready      = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    out_load     = 1'b0;
    case (state)
      S_LOAD: begin
        q_ready = 1'b1;
        if (q_valid && q_item.last) begin
          state_next = S_SETTLE;
        end
      end
      // The settle state lets the last product reach the weighted sum.
      S_SETTLE: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (ovf || (total == '0)) begin
          state_next = S_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(wsum_mag);
          state_next   = S_MDIV;
        end
      end
      S_MDIV: begin
        if (div_done) begin
          state_next = S_PASS;
        end
      end
      S_PASS: begin
        if (pass_end) begin
          div_start    = 1'b1;
          div_dividend = DIVD_W'(dev_sum);
          state_next   = S_DDIV;
        end
      end
      S_DDIV: begin
        if (div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Pair storage: one write port on load, one registered read port on the pass.
  always_ff @(posedge clk) begin
    if (pop && (q_item.kind == K_STORE)) begin
      mem[q_item.idx] <= {q_item.mark, q_item.freq};
    end
    rd_word <= mem[rd_idx[IDX_W-1:0]];
  end

  // The absolute difference is registered before the multiply.
  always_ff @(posedge clk) begin
    prod    <= $signed(q_item.mark) * $signed({1'b0, q_item.freq});
    adiff_r <= adiff;
    freq_r  <= rd_word[FREQ_W-1:0];
    dprod   <= adiff_r * freq_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_stored <= '0;
      total    <= '0;
      wsum     <= '0;
      ovf      <= 1'b0;
      prod_v   <= 1'b0;
      rd_idx   <= '0;
      rd_v     <= 1'b0;
      adiff_v  <= 1'b0;
      dprod_v  <= 1'b0;
      dev_sum  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      prod_v  <= pop && (q_item.kind == K_STORE);
      rd_v    <= issue;
      adiff_v <= rd_v;
      dprod_v <= adiff_v;

      if (pop) begin
        if (q_item.kind == K_STORE) begin
          n_stored <= n_stored + 1'b1;
          total    <= total + TOT_W'(q_item.freq);
        end else begin
          ovf <= 1'b1;
        end
      end
      if (prod_v) begin
        wsum <= wsum + WSUM_W'(prod);
      end

      if ((state == S_MDIV) && div_done) begin
        rd_idx  <= '0;
        dev_sum <= '0;
      end else begin
        if (issue) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (dprod_v) begin
          dev_sum <= dev_sum + DEVS_W'(dprod);
        end
      end

      if (out_load) begin
        m_tvalid <= 1'b1;
        n_stored <= '0;
        total    <= '0;
        wsum     <= '0;
        ovf      <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CHECK) begin
      res_mean   <= '0;
      res_dev    <= '0;
      res_status <= ovf ? ST_OVF : ((total == '0) ? ST_ZERO : ST_OK);
    end
    if ((state == S_MDIV) && div_done) begin
      res_mean <= wsum[WSUM_W-1] ? -div_q[MARK_W-1:0] : div_q[MARK_W-1:0];
    end
    if ((state == S_DDIV) && div_done) begin
      res_dev <= (|div_q[DIVD_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
    end
    if (out_load) begin
      m_tdata <= {res_dev, res_mean};
      m_tuser <= res_status;
    end
  end

endmodule

### src/weighted_mean_abs_deviation.sv
// Weighted mean absolute deviation: loads one pair per cycle into on-chip store while the
// back end is in its load state; otherwise s_tready drops once the input queue is full.
// After a set's last transaction the mean division, the read pass over the n stored pairs
// and the deviation division run serially (DIVD_W = 58 bits); an error set skips all three.
// Synchronous active-high reset clears control and sums; the pair memory is not
// cleared, since only entries written in the current set are read.
module weighted_mean_abs_deviation import wmad_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // class_mark [31:0], class_frequency [47:32]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // weighted_mean [31:0], mean_abs_dev [63:32]
  output logic [1:0]  m_tuser    // status [1:0]
);

  logic     q_valid;
  item_t    q_item;
  logic     q_ready;
  fe_stat_t fe_stat;
  bk_stat_t bk_stat;

  wmad_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mark     (s_tdata[MARK_W-1:0]),
    .freq     (s_tdata[MARK_W+FREQ_W-1:MARK_W]),
    .last     (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .stat     (fe_stat)
  );

  wmad_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .stat     (bk_stat)
  );

  // An error result carries zero mean and zero deviation.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == '0))
    else $error("error result with nonzero data");

  // An accepted transaction is queued for the back end.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> fe_stat.q_nonempty)
    else $error("accepted transaction not queued");

  // The divider only runs after loading of a set has ended.
  assert property (@(posedge clk) disable iff (rst)
    !(bk_stat.in_load && bk_stat.div_busy))
    else $error("divider busy while loading");

endmodule
